>>> hw/rtl/scld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scld_pkg;

  // line assembly limits
  localparam int LINE_LIMIT = 200;
  localparam int CNT_W      = $clog2(LINE_LIMIT);
  localparam int HEAD_BYTES = 4;
  localparam int HEAD_IDX_W = $clog2(HEAD_BYTES);

  // character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_F     = 8'h46;

  typedef enum logic [1:0] {
    TGT_HUMIDITY    = 2'd0,
    TGT_TEMPERATURE = 2'd1,
    TGT_LIGHT       = 2'd2,
    TGT_FILTER      = 2'd3
  } target_t;

  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_BAD = 1'b1
  } status_t;

  // one decoded line; flags indexed by target_t
  typedef struct packed {
    status_t    cmd_status;
    target_t    target;
    logic       new_value;
    logic [3:0] flags;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/serial_command_line_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Serial command line decoder. Takes one received byte per transfer and
// assembles lines ending in CR LF; on CR LF the first four line bytes are
// decoded as a command X=V (X one of H, T, L, F; V '0' or '1'; fourth byte
// zero) and one result transfer carries the status, the addressed flag, the
// written value and all four enable flags. Bytes that do not end a line give
// no result. A byte after CR other than LF restarts the line and is dropped.
// Rate: one byte per clock unless a line-ending byte waits on a stalled
// result. A byte passes an input register and, when it ends a line, lands
// in the result register, which offers the result. The input register
// keeps taking bytes while a result waits.

module serial_command_line_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // byte input
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  // result output
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_cmd_status,
  output logic [1:0]      out_target,
  output logic            out_new_value,
  output logic            out_humidity_enable,
  output logic            out_temperature_enable,
  output logic            out_light_enable,
  output logic            out_filtering_enable
);

  // input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] byte_r;

  // result register
  logic              out_v_r, out_v_nxt;
  scld_pkg::result_t res_r;
  scld_pkg::result_t res;

  logic line_end;
  logic out_free;
  logic advance;
  logic in_take;

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_v_r || !out_stall;
  // only a line-ending byte needs the result slot
  assign advance  = in_v_r && (!line_end || out_free);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  scld_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .rx_byte  (byte_r),
    .line_end (line_end),
    .res      (res)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (advance && line_end) begin
      out_v_nxt = 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_rx_byte;
    end
    if (advance && line_end) begin
      res_r <= res;
    end
  end

  assign out_valid              = out_v_r;
  assign out_cmd_status         = res_r.cmd_status;
  assign out_target             = res_r.target;
  assign out_new_value          = res_r.new_value;
  assign out_humidity_enable    = res_r.flags[scld_pkg::TGT_HUMIDITY];
  assign out_temperature_enable = res_r.flags[scld_pkg::TGT_TEMPERATURE];
  assign out_light_enable       = res_r.flags[scld_pkg::TGT_LIGHT];
  assign out_filtering_enable   = res_r.flags[scld_pkg::TGT_FILTER];

endmodule

`default_nettype wire

>>> hw/rtl/scld_core.sv
`timescale 1ns / 1ps
`default_nettype none

module scld_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        rx_byte,
  output logic                   line_end,
  output scld_pkg::result_t      res
);

  logic                                 cr_seen_r, cr_seen_nxt;
  logic [scld_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [scld_pkg::HEAD_BYTES-1:0][7:0] head_r, head_nxt;
  logic [3:0]                           flags_r, flags_nxt;

  logic              cmd_ok;
  logic              known;
  scld_pkg::target_t tgt;
  logic              bit_val;

  assign line_end = cr_seen_r && (rx_byte == scld_pkg::CH_LF);

  // decode of the held head bytes
  always_comb begin
    cmd_ok  = (head_r[1] == scld_pkg::CH_EQUAL) && (head_r[3] == scld_pkg::CH_NUL) &&
              ((head_r[2] == scld_pkg::CH_ZERO) || (head_r[2] == scld_pkg::CH_ONE));
    bit_val = (head_r[2] == scld_pkg::CH_ONE);
    known   = 1'b1;
    case (head_r[0])
      scld_pkg::CH_H: tgt = scld_pkg::TGT_HUMIDITY;
      scld_pkg::CH_T: tgt = scld_pkg::TGT_TEMPERATURE;
      scld_pkg::CH_L: tgt = scld_pkg::TGT_LIGHT;
      scld_pkg::CH_F: tgt = scld_pkg::TGT_FILTER;
      default: begin
        tgt   = scld_pkg::TGT_HUMIDITY;
        known = 1'b0;
      end
    endcase
  end

  always_comb begin
    cr_seen_nxt = cr_seen_r;
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    flags_nxt   = flags_r;
    if (step) begin
      if (cr_seen_r) begin
        cr_seen_nxt = 1'b0;
        cnt_nxt     = '0;
        if (line_end) begin
          head_nxt = '0;
          if (cmd_ok && known) begin
            flags_nxt[tgt] = bit_val;
          end
        end
      end else if (rx_byte == scld_pkg::CH_CR) begin
        cr_seen_nxt = 1'b1;
      end else begin
        if (cnt_r < scld_pkg::CNT_W'(scld_pkg::HEAD_BYTES)) begin
          head_nxt[cnt_r[scld_pkg::HEAD_IDX_W-1:0]] = rx_byte;
        end
        // wrap at the line limit
        if (cnt_r == scld_pkg::CNT_W'(scld_pkg::LINE_LIMIT - 1)) begin
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    res.flags = flags_nxt;
    if (cmd_ok && known) begin
      res.cmd_status = scld_pkg::STATUS_OK;
      res.target     = tgt;
      res.new_value  = bit_val;
    end else begin
      res.cmd_status = scld_pkg::STATUS_BAD;
      res.target     = scld_pkg::TGT_HUMIDITY;
      res.new_value  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_seen_r <= 1'b0;
      cnt_r     <= '0;
      head_r    <= '0;
      flags_r   <= '0;
    end else begin
      cr_seen_r <= cr_seen_nxt;
      cnt_r     <= cnt_nxt;
      head_r    <= head_nxt;
      flags_r   <= flags_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/scld_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module scld_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_cmd_status,
  input wire logic [1:0] out_target,
  input wire logic       out_new_value,
  input wire logic       out_humidity_enable,
  input wire logic       out_temperature_enable,
  input wire logic       out_light_enable,
  input wire logic       out_filtering_enable
);

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cmd_status) &&
      $stable(out_target) && $stable(out_new_value) &&
      $stable(out_humidity_enable) && $stable(out_temperature_enable) &&
      $stable(out_light_enable) && $stable(out_filtering_enable))
    else $error("stalled result changed");

  // rejected command reports zero target and value
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_cmd_status == scld_pkg::STATUS_BAD) |->
      (out_target == scld_pkg::TGT_HUMIDITY) && !out_new_value)
    else $error("rejected command with nonzero target or value");

  // accepted command shows the written value in its flag
  a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_cmd_status == scld_pkg::STATUS_OK) |->
      (out_target != scld_pkg::TGT_HUMIDITY || out_humidity_enable == out_new_value) &&
      (out_target != scld_pkg::TGT_TEMPERATURE ||
       out_temperature_enable == out_new_value) &&
      (out_target != scld_pkg::TGT_LIGHT || out_light_enable == out_new_value) &&
      (out_target != scld_pkg::TGT_FILTER || out_filtering_enable == out_new_value))
    else $error("flag does not match written value");

endmodule

bind serial_command_line_decoder scld_checker u_scld_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_cmd_status         (out_cmd_status),
  .out_target             (out_target),
  .out_new_value          (out_new_value),
  .out_humidity_enable    (out_humidity_enable),
  .out_temperature_enable (out_temperature_enable),
  .out_light_enable       (out_light_enable),
  .out_filtering_enable   (out_filtering_enable)
);

`default_nettype wire
